[hw/rtl/lfpmst_pkg.sv]
package lfpmst_pkg;

	// Width of one value slot and the empty marker.
	localparam int VW = 30;
	localparam logic [VW-1:0] EMPTY_VALUE = 30'h3f3f3f3f;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		FN_SET   = 2'd0,
		FN_READ  = 2'd1,
		FN_QUERY = 2'd2,
		FN_SWAP  = 2'd3
	} func_t;

	// One tree memory entry: slot minima and the pending swap mark.
	typedef struct packed {
		logic          flip;
		logic [VW-1:0] b;
		logic [VW-1:0] a;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_PSEL,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_MCHK,
		ST_ARD,
		ST_AWT,
		ST_SET,
		ST_RRD,
		ST_RWT,
		ST_USEL,
		ST_U0,
		ST_U1,
		ST_U2,
		ST_FIN
	} state_t;

	// Swap both slots; internal nodes also toggle their pending mark.
	function automatic node_t apply_swap(node_t n, logic is_leaf);
		node_t r;
		r.a = n.b;
		r.b = n.a;
		r.flip = n.flip ^ ~is_leaf;
		return r;
	endfunction

	function automatic logic [VW-1:0] vmin(logic [VW-1:0] x, logic [VW-1:0] y);
		return (x < y) ? x : y;
	endfunction

endpackage

[hw/rtl/lfpmst_ram.sv]
module lfpmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/lazy_flip_pair_min_segment_tree_core.sv]
// Channel   Direction  Word contents (lowest bit first)
// s_*       in         tuser: func; tdata: first_index, end_index, new_slot_a, new_slot_b
// m_*       out        tuser: index_error; tdata: slot_a_result, slot_b_result
//
// Every tree node and leaf sits in one memory with a registered read.
// A word walks the boundary ancestors in a push pass from the root down
// and, for set and swap, in a merge pass back up; for query and swap the
// range cover walk follows the push pass. A word with an index error or
// an empty range skips the walks and goes straight to the finish state.
// After reset a clearing pass writes all 2*2^ceil(log2(LEAVES)) entries, one
// per cycle, before the first word is taken. A stalled output holds the
// finished word while the next input word is already taken and worked on.
module lazy_flip_pair_min_segment_tree_core
	import lfpmst_pkg::*;
#(
	parameter int LEAVES     = 1024,
	parameter int VALUE_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // func
	input  logic [87:0] s_tdata,   // first_index, end_index, new_slot_a, new_slot_b
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,   // index_error
	output logic [63:0] m_tdata    // slot_a_result, slot_b_result
);

	localparam int LOG  = $clog2(LEAVES);
	localparam int SPAN = 1 << LOG;
	localparam int NODES = 2 * SPAN;
	localparam int AW   = LOG + 1;
	localparam int NW   = AW + 1;
	localparam int LVW  = $clog2(LOG + 2);
	localparam logic [VW-1:0] VMASK =
		(VALUE_BITS >= VW) ? {VW{1'b1}} : VW'((64'd1 << VALUE_BITS) - 64'd1);

	// Input word fields.
	logic [9:0]    first_in;
	logic [10:0]   end_in;
	logic [VW-1:0] a_in;
	logic [VW-1:0] b_in;
	assign first_in = s_tdata[9:0];
	assign end_in   = s_tdata[20:10];
	assign a_in     = s_tdata[50:21];
	assign b_in     = s_tdata[80:51];

	state_t state_q, state_d;
	logic [LVW-1:0] lvl_q, lvl_d;
	logic side_q, side_d;
	logic [AW-1:0] node_q, node_d;
	logic [NW-1:0] lb_q, lb_d, rb_q, rb_d, l_q, l_d, r_q, r_d;
	func_t func_q, func_d;
	logic [VW-1:0] acc_a_q, acc_a_d, acc_b_q, acc_b_d;
	logic [VW-1:0] set_a_q, set_a_d, set_b_q, set_b_d;
	logic err_q, err_d;
	node_t tmp_q, tmp_d;
	logic [AW-1:0] clr_q, clr_d;
	logic mv_q, mv_d;
	logic [VW-1:0] out_a_q, out_b_q;
	logic out_err_q;

	// Memory port signals.
	logic we;
	logic [AW-1:0] waddr, raddr;
	node_t wnode, rnode;
	logic [NODE_BITS-1:0] rdata;
	assign rnode = node_t'(rdata);

	lfpmst_ram #(
		.WIDTH(NODE_BITS),
		.DEPTH(NODES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(NODE_BITS'(wnode)),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Boundary ancestors at the current level.
	logic [NW-1:0] rb_m1, lmask;
	logic [AW-1:0] anc_l, anc_r, node_x2;
	logic accept, out_load;
	logic in_err, in_empty;
	assign rb_m1   = rb_q - NW'(1);
	assign anc_l   = AW'(lb_q >> lvl_q);
	assign anc_r   = AW'(rb_m1 >> lvl_q);
	assign lmask   = (NW'(1) << lvl_q) - NW'(1);
	assign node_x2 = {node_q[AW-2:0], 1'b0};

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_FIN) && (!mv_q || m_tready);

	// Input checks against the store size.
	always_comb begin
		in_err   = 1'b0;
		in_empty = 1'b0;
		unique case (func_t'(s_tuser))
			FN_SET, FN_READ: begin
				in_err = (32'(first_in) >= LEAVES);
			end
			FN_QUERY, FN_SWAP: begin
				in_err   = (32'(end_in) > LEAVES);
				in_empty = ({1'b0, first_in} >= end_in);
			end
		endcase
	end

	// Next state, datapath updates and memory control.
	always_comb begin
		state_d = state_q;
		lvl_d   = lvl_q;
		side_d  = side_q;
		node_d  = node_q;
		lb_d    = lb_q;
		rb_d    = rb_q;
		l_d     = l_q;
		r_d     = r_q;
		func_d  = func_q;
		acc_a_d = acc_a_q;
		acc_b_d = acc_b_q;
		set_a_d = set_a_q;
		set_b_d = set_b_q;
		err_d   = err_q;
		tmp_d   = tmp_q;
		clr_d   = clr_q;
		we      = 1'b0;
		waddr   = node_q;
		wnode   = '0;
		raddr   = '0;

		unique case (state_q)
			ST_CLR: begin
				we = 1'b1;
				waddr = clr_q;
				wnode = '{flip: 1'b0, b: EMPTY_VALUE, a: EMPTY_VALUE};
				clr_d = clr_q + AW'(1);
				if (clr_q == {AW{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					func_d  = func_t'(s_tuser);
					acc_a_d = EMPTY_VALUE;
					acc_b_d = EMPTY_VALUE;
					set_a_d = a_in & VMASK;
					set_b_d = b_in & VMASK;
					err_d   = in_err;
					lb_d    = NW'(SPAN) + NW'(first_in);
					if (func_t'(s_tuser) == FN_SET || func_t'(s_tuser) == FN_READ) begin
						rb_d = NW'(SPAN) + NW'(first_in) + NW'(1);
					end else begin
						rb_d = NW'(SPAN) + NW'(end_in);
					end
					lvl_d  = LVW'(LOG);
					side_d = 1'b0;
					if (in_err || in_empty) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_PSEL;
					end
				end
			end
			// Push pass: ancestors of both boundaries, root first.
			ST_PSEL: begin
				if (lvl_q == '0) begin
					unique case (func_q)
						FN_SET: state_d = ST_SET;
						FN_READ: state_d = ST_RRD;
						FN_QUERY, FN_SWAP: begin
							l_d = lb_q;
							r_d = rb_q;
							state_d = ST_MCHK;
						end
					endcase
				end else if (!side_q) begin
					node_d  = anc_l;
					side_d  = 1'b1;
					state_d = ST_P0;
				end else begin
					side_d = 1'b0;
					lvl_d  = lvl_q - LVW'(1);
					if (anc_r != anc_l) begin
						node_d  = anc_r;
						state_d = ST_P0;
					end
				end
			end
			ST_P0: begin
				raddr   = node_q;
				state_d = ST_P1;
			end
			ST_P1: begin
				if (rnode.flip) begin
					we = 1'b1;
					waddr = node_q;
					wnode = '{flip: 1'b0, b: rnode.b, a: rnode.a};
					raddr = node_x2;
					state_d = ST_P2;
				end else begin
					state_d = ST_PSEL;
				end
			end
			ST_P2: begin
				we = 1'b1;
				waddr = node_x2;
				wnode = apply_swap(rnode, node_x2[AW-1]);
				raddr = node_x2 | AW'(1);
				state_d = ST_P3;
			end
			ST_P3: begin
				we = 1'b1;
				waddr = node_x2 | AW'(1);
				wnode = apply_swap(rnode, node_x2[AW-1]);
				state_d = ST_PSEL;
			end
			// Range cover walk, bottom up from both ends.
			ST_MCHK: begin
				if (l_q < r_q) begin
					if (l_q[0]) begin
						node_d  = AW'(l_q);
						l_d     = l_q + NW'(1);
						state_d = ST_ARD;
					end else if (r_q[0]) begin
						node_d  = AW'(r_q - NW'(1));
						r_d     = r_q - NW'(1);
						state_d = ST_ARD;
					end else begin
						l_d = l_q >> 1;
						r_d = r_q >> 1;
					end
				end else if (func_q == FN_SWAP) begin
					lvl_d   = LVW'(1);
					side_d  = 1'b0;
					state_d = ST_USEL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_ARD: begin
				raddr   = node_q;
				state_d = ST_AWT;
			end
			ST_AWT: begin
				if (func_q == FN_SWAP) begin
					we = 1'b1;
					waddr = node_q;
					wnode = apply_swap(rnode, node_q[AW-1]);
				end else begin
					acc_a_d = vmin(acc_a_q, rnode.a);
					acc_b_d = vmin(acc_b_q, rnode.b);
				end
				state_d = ST_MCHK;
			end
			ST_SET: begin
				we = 1'b1;
				waddr = AW'(lb_q);
				wnode = '{flip: 1'b0, b: set_b_q, a: set_a_q};
				lvl_d = LVW'(1);
				side_d = 1'b0;
				state_d = ST_USEL;
			end
			ST_RRD: begin
				raddr   = AW'(lb_q);
				state_d = ST_RWT;
			end
			ST_RWT: begin
				acc_a_d = rnode.a;
				acc_b_d = rnode.b;
				state_d = ST_FIN;
			end
			// Merge pass: partly covered ancestors, lowest level first.
			ST_USEL: begin
				if (lvl_q == LVW'(LOG + 1)) begin
					state_d = ST_FIN;
				end else if (!side_q) begin
					side_d = 1'b1;
					if ((lb_q & lmask) != '0) begin
						node_d  = anc_l;
						state_d = ST_U0;
					end
				end else begin
					side_d = 1'b0;
					lvl_d  = lvl_q + LVW'(1);
					if ((rb_q & lmask) != '0) begin
						node_d  = anc_r;
						state_d = ST_U0;
					end
				end
			end
			ST_U0: begin
				raddr   = node_x2;
				state_d = ST_U1;
			end
			ST_U1: begin
				tmp_d   = rnode;
				raddr   = node_x2 | AW'(1);
				state_d = ST_U2;
			end
			ST_U2: begin
				we = 1'b1;
				waddr = node_q;
				wnode = '{flip: 1'b0, b: vmin(tmp_q.b, rnode.b), a: vmin(tmp_q.a, rnode.a)};
				state_d = ST_USEL;
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (out_load) begin
			mv_d = 1'b1;
		end else if (m_tready) begin
			mv_d = 1'b0;
		end else begin
			mv_d = mv_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			mv_q    <= 1'b0;
			lvl_q   <= '0;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			mv_q    <= mv_d;
			lvl_q   <= lvl_d;
			side_q  <= side_d;
		end
	end

	// Working registers and the output word.
	always_ff @(posedge clk) begin
		node_q  <= node_d;
		lb_q    <= lb_d;
		rb_q    <= rb_d;
		l_q     <= l_d;
		r_q     <= r_d;
		func_q  <= func_d;
		acc_a_q <= acc_a_d;
		acc_b_q <= acc_b_d;
		set_a_q <= set_a_d;
		set_b_q <= set_b_d;
		err_q   <= err_d;
		tmp_q   <= tmp_d;
		if (out_load) begin
			out_a_q   <= acc_a_q;
			out_b_q   <= acc_b_q;
			out_err_q <= err_q;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = out_err_q;
	assign m_tdata  = {4'b0, out_b_q, out_a_q};

	// No word is taken while the clearing pass runs.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_tready)
		else $error("input taken during clearing pass");

	// Outside the clearing pass, the sequencer never reads an entry in the cycle that writes it.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != ST_CLR) |-> (waddr != raddr))
		else $error("read and write to the same entry in one cycle");

	// An index error always comes with empty slot results.
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[59:0] == {EMPTY_VALUE, EMPTY_VALUE}))
		else $error("index error with non-empty result");

endmodule

[tb/tb_lazy_flip_pair_min_segment_tree_checker.sv]
`timescale 1ns / 1ps

module tb_lazy_flip_pair_min_segment_tree_checker
	import lfpmst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  logic [87:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic        m_tuser,
	input  logic [63:0] m_tdata,
	output int          fail_count,
	output int          pending_count
);

	localparam int N = 1024;
	localparam int QD = 8;

	// Flat model of the store: the lazy tree is only an implementation of this.
	logic [VW-1:0] pos_a [N];
	logic [VW-1:0] pos_b [N];

	typedef struct packed {
		logic          err;
		logic [VW-1:0] b;
		logic [VW-1:0] a;
	} answer_t;

	// Ring of answers still owed by the block.
	answer_t answer_mem [QD];
	int      wr_cnt;
	int      rd_cnt;

	assign pending_count = wr_cnt - rd_cnt;

	// Apply one accepted word to the store and compute the answer it must give.
	function automatic answer_t serve_word(logic [1:0] fn, logic [87:0] d);
		answer_t r;
		logic [9:0] fi;
		logic [10:0] ei;
		logic [VW-1:0] t;
		fi = d[9:0];
		ei = d[20:10];
		r.a = EMPTY_VALUE;
		r.b = EMPTY_VALUE;
		r.err = 1'b0;
		case (fn)
			FN_SET: begin
				pos_a[fi] = d[50:21];
				pos_b[fi] = d[80:51];
			end
			FN_READ: begin
				r.a = pos_a[fi];
				r.b = pos_b[fi];
			end
			default: begin
				if (ei > N) begin
					r.err = 1'b1;
				end else begin
					for (int i = fi; i < ei; i++) begin
						if (fn == FN_QUERY) begin
							if (pos_a[i] < r.a) r.a = pos_a[i];
							if (pos_b[i] < r.b) r.b = pos_b[i];
						end else begin
							t = pos_a[i];
							pos_a[i] = pos_b[i];
							pos_b[i] = t;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	// Predict on input words and compare output words against the oldest answer.
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			fail_count <= 0;
			wr_cnt <= 0;
			rd_cnt <= 0;
			for (int i = 0; i < N; i++) begin
				pos_a[i] = EMPTY_VALUE;
				pos_b[i] = EMPTY_VALUE;
			end
		end else begin
			if (m_tvalid && m_tready) begin
				if (rd_cnt == wr_cnt) begin
					$display("%0t: unexpected word err=%b a=%h b=%h", $time, m_tuser,
						m_tdata[29:0], m_tdata[59:30]);
					fail_count <= fail_count + 1;
				end else begin
					want = answer_mem[rd_cnt % QD];
					rd_cnt <= rd_cnt + 1;
					if (m_tuser !== want.err || m_tdata[29:0] !== want.a ||
							m_tdata[59:30] !== want.b || m_tdata[63:60] !== 4'd0) begin
						$display("%0t: expected err=%b a=%h b=%h, got err=%b a=%h b=%h",
							$time, want.err, want.a, want.b, m_tuser, m_tdata[29:0],
							m_tdata[59:30]);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				answer_mem[wr_cnt % QD] <= serve_word(s_tuser, s_tdata);
				wr_cnt <= wr_cnt + 1;
			end
		end
	end

endmodule

[tb/tb_lazy_flip_pair_min_segment_tree_core.sv]
`timescale 1ns / 1ps

module tb_lazy_flip_pair_min_segment_tree_core
	import lfpmst_pkg::*;
();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [87:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        m_tuser;
	logic [63:0] m_tdata;
	int          fail_count;
	int          pending_count;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          cycles = 0;

	localparam int CYCLE_LIMIT = 2000000;

	always #10 clk = ~clk;

	lazy_flip_pair_min_segment_tree_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	tb_lazy_flip_pair_min_segment_tree_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Receiver stalls at random at the current rate.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one word, idle at random first, and hold it until it is taken.
	task automatic send_word(func_t fn, logic [9:0] fi, logic [10:0] ei,
			logic [29:0] va, logic [29:0] vb);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {7'd0, vb, va, ei, fi};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Values mostly full width; sometimes small so minima collide, sometimes empty.
	function automatic logic [29:0] pick_value();
		case ($urandom_range(3))
			0: return 30'($urandom_range(15));
			1: return EMPTY_VALUE;
			default: return 30'($urandom());
		endcase
	endfunction

	task automatic random_word();
		func_t fn;
		logic [9:0] fi;
		logic [10:0] ei;
		fn = func_t'($urandom_range(3));
		if ($urandom_range(3) == 0) begin
			fi = 10'($urandom());
			ei = 11'($urandom());
		end else begin
			// Narrow window so that sets, swaps and queries hit the same places.
			fi = 10'($urandom_range(40)) + ($urandom_range(1) ? 10'd980 : 10'd0);
			ei = 11'(fi) + 11'($urandom_range(45));
		end
		send_word(fn, fi, ei, pick_value(), pick_value());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every operation, errors and empty ranges.
		send_word(FN_READ, 10'd0, 11'd0, '0, '0);
		send_word(FN_QUERY, 10'd0, 11'd1024, '0, '0);
		send_word(FN_SET, 10'd0, 11'd0, 30'd0, 30'h3fffffff);
		send_word(FN_SET, 10'd1023, 11'h7ff, 30'h3fffffff, 30'd5);
		send_word(FN_SET, 10'd512, 11'd0, 30'd7, EMPTY_VALUE);
		send_word(FN_READ, 10'd1023, 11'd0, '0, '0);
		send_word(FN_QUERY, 10'd0, 11'd1024, '0, '0);
		send_word(FN_SWAP, 10'd0, 11'd1024, '0, '0);
		send_word(FN_QUERY, 10'd1, 11'd1024, '0, '0);
		send_word(FN_SWAP, 10'd500, 11'd1000, '0, '0);
		send_word(FN_READ, 10'd512, 11'd0, '0, '0);
		send_word(FN_READ, 10'd0, 11'd0, '0, '0);
		send_word(FN_QUERY, 10'd5, 11'd5, '0, '0);
		send_word(FN_SWAP, 10'd900, 11'd3, '0, '0);
		send_word(FN_QUERY, 10'd0, 11'd1025, '0, '0);
		send_word(FN_SWAP, 10'd3, 11'h7ff, '0, '0);
		send_word(FN_QUERY, 10'h3ff, 11'd1024, '0, '0);
		send_word(FN_SWAP, 10'd1023, 11'd1024, '0, '0);
		send_word(FN_READ, 10'd1023, 11'd0, '0, '0);

		// Random phases with changing idle rates.
		send_idle = 21;
		recv_idle = 85;
		repeat (500) random_word();
		send_idle = 85;
		recv_idle = 21;
		repeat (500) random_word();
		send_idle = 0;
		recv_idle = 0;
		repeat (500) random_word();
		s_tvalid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[lazy_flip_pair_min_segment_tree_core.f]
hw/rtl/lfpmst_pkg.sv
hw/rtl/lfpmst_ram.sv
hw/rtl/lazy_flip_pair_min_segment_tree_core.sv
tb/tb_lazy_flip_pair_min_segment_tree_checker.sv
tb/tb_lazy_flip_pair_min_segment_tree_core.sv
